// ===== hw/rtl/imm_pkg.sv =====
`default_nettype none

package imm_pkg;

	localparam int MODE_W     = 2;
	localparam int IDX_W      = 5;
	localparam int VAL_W      = 64;
	localparam int SIZE_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 6;

	localparam logic [MODE_W-1:0] MODE_WR_A = 2'd0;
	localparam logic [MODE_W-1:0] MODE_WR_B = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RD   = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BT   = 2'd1;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

	// partial product selected in the shared multiplier
	localparam logic [1:0] PH_LL = 2'd0;  // a[31:0]  * b[31:0]
	localparam logic [1:0] PH_LH = 2'd1;  // a[31:0]  * b[63:32], shifted up 32
	localparam logic [1:0] PH_HL = 2'd2;  // a[63:32] * b[31:0],  shifted up 32

	typedef struct packed {
		logic       clear;
		logic       mul_en;
		logic [1:0] phase;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/imm_mac.sv =====
`default_nettype none

module imm_mac (
	input  logic                     clk,
	input  logic                     arst_n,
	input  imm_pkg::mac_ctl_t        ctl,
	input  logic [imm_pkg::VAL_W-1:0] op_a,
	input  logic [imm_pkg::VAL_W-1:0] op_b,
	output logic [imm_pkg::VAL_W-1:0] acc_sum
);
	import imm_pkg::*;

	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [63:0]      mul_p;
	logic [VAL_W-1:0] prod_q;
	logic [VAL_W-1:0] acc_q;
	logic             add_v_q;

	assign mul_a   = (ctl.phase == PH_HL) ? op_a[63:32] : op_a[31:0];
	assign mul_b   = (ctl.phase == PH_LH) ? op_b[63:32] : op_b[31:0];
	assign mul_p   = 64'(mul_a) * 64'(mul_b);
	assign acc_sum = acc_q + (add_v_q ? prod_q : '0);

	// hold each product in a register, then add it in
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			add_v_q <= 1'b0;
		end else if (ctl.clear) begin
			add_v_q <= 1'b0;
		end else begin
			add_v_q <= ctl.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			acc_q <= '0;
		end else begin
			acc_q <= acc_sum;
		end
		if (ctl.mul_en) begin
			if (ctl.phase == PH_LL) begin
				prod_q <= mul_p;
			end else begin
				prod_q <= {mul_p[31:0], 32'd0};
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_matrix_multiply.sv =====
// Square 64-bit matrix product modulo 2^64; element writes complete at the transfer edge, one per cycle while not busy.
// Product read: FETCH, then MAC for n terms (n = size in use, n = 0 when an index is out
// of range, which skips to DRAIN), then DRAIN; done follows, and the next start is taken
// in the strobe cycle. The single 32x32 multiplier is used three times for each term.
// The receiver cannot stall: done is a one-cycle strobe with its result.
// arst_n clears control and configuration (size 32, B not transposed); stores are not cleared.
`default_nettype none

module integer_matrix_multiply #(
	parameter int MAX_DIM = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [imm_pkg::MODE_W-1:0]     mode,
	input  logic [imm_pkg::IDX_W-1:0]      row_index,
	input  logic [imm_pkg::IDX_W-1:0]      col_index,
	input  logic [imm_pkg::VAL_W-1:0]      element_value,
	output logic                          done,
	output logic [imm_pkg::IDX_W-1:0]      result_row,
	output logic [imm_pkg::IDX_W-1:0]      result_col,
	output logic [imm_pkg::VAL_W-1:0]      product_value,
	input  logic                          cfg_we,
	input  logic [imm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [imm_pkg::CFG_DATA_W-1:0] cfg_data
);
	import imm_pkg::*;

	localparam int DEPTH = MAX_DIM * MAX_DIM;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_W = $clog2(MAX_DIM + 1);
	// wide enough for the size register, the saturated size and the term counter
	localparam int W     = (DIM_W > SIZE_W) ? DIM_W : SIZE_W;

	localparam logic [W-1:0]  DIM_LIM = W'(MAX_DIM);
	localparam logic [AW-1:0] DIM_A   = AW'(MAX_DIM);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_FETCH = 2'd1;  // first operand read in flight
	localparam logic [1:0] ST_MAC   = 2'd2;  // three partial products per term
	localparam logic [1:0] ST_DRAIN = 2'd3;  // last add lands, result registered

	// configuration
	logic [SIZE_W-1:0] size_q;
	logic              bt_q;

	// sequencer
	logic [1:0]       state_q;
	logic [1:0]       phase_q;
	logic [W-1:0]     k_q;  // index of the next term to read
	logic [IDX_W-1:0] row_q;
	logic [IDX_W-1:0] col_q;

	// result
	logic             done_q;
	logic [IDX_W-1:0] res_row_q;
	logic [IDX_W-1:0] res_col_q;
	logic [VAL_W-1:0] res_val_q;

	// stores
	logic [VAL_W-1:0] mem_a [DEPTH];
	logic [VAL_W-1:0] mem_b [DEPTH];
	logic [VAL_W-1:0] rd_a_q;
	logic [VAL_W-1:0] rd_b_q;

	logic [W-1:0]     size_ext;
	logic [W-1:0]     n_use;
	logic             accept;
	logic             in_rng;
	logic             more_terms;
	logic             rd_en;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr_a;
	logic [AW-1:0]    rd_addr_b;
	mac_ctl_t         mac_ctl;
	logic [VAL_W-1:0] acc_sum;

	// saturate the size at the store dimension; size zero leaves every index out of range
	assign size_ext = W'(size_q);
	assign n_use    = (size_ext > DIM_LIM) ? DIM_LIM : size_ext;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign in_rng = (W'(row_index) < n_use) && (W'(col_index) < n_use);

	assign more_terms = (k_q < n_use);

	// issue the first read from FETCH, and the next term's read in the last phase
	// so its operands are registered when phase LL of that term begins
	assign rd_en = (state_q == ST_FETCH) ||
		((state_q == ST_MAC) && (phase_q == PH_HL) && more_terms);

	// row-major addressing; with B transposed, walk row col of B instead of column col
	assign wr_addr   = AW'(row_index) * DIM_A + AW'(col_index);
	assign rd_addr_a = AW'(row_q) * DIM_A + AW'(k_q);
	assign rd_addr_b = bt_q ? (AW'(col_q) * DIM_A + AW'(k_q))
	                        : (AW'(k_q) * DIM_A + AW'(col_q));

	assign mac_ctl.clear  = accept;
	assign mac_ctl.mul_en = (state_q == ST_MAC);
	assign mac_ctl.phase  = phase_q;

	imm_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (mac_ctl),
		.op_a    (rd_a_q),
		.op_b    (rd_b_q),
		.acc_sum (acc_sum)
	);

	// Element writes complete at the transfer edge; out-of-range writes drop.
	// Reads happen only while busy, so a port never sees both in one cycle.
	always_ff @(posedge clk) begin
		if (accept && in_rng && (mode == MODE_WR_A)) begin
			mem_a[wr_addr] <= element_value;
		end
		if (accept && in_rng && (mode == MODE_WR_B)) begin
			mem_b[wr_addr] <= element_value;
		end
		if (rd_en) begin
			rd_a_q <= mem_a[rd_addr_a];
			rd_b_q <= mem_b[rd_addr_b];
		end
	end

	// control and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q  <= SIZE_RESET;
			bt_q    <= 1'b0;
			state_q <= ST_IDLE;
			phase_q <= PH_LL;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			// raise the strobe for one cycle as the result is registered
			done_q <= (state_q == ST_DRAIN);
			if (cfg_we) begin
				case (cfg_index)
					REG_SIZE: size_q <= cfg_data[SIZE_W-1:0];
					REG_BT:   bt_q   <= cfg_data[0];
					default: ;  // unused index: drop the write
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					// a product read always yields a result; mode 3 is dropped
					if (accept && (mode == MODE_RD)) begin
						k_q     <= '0;
						phase_q <= PH_LL;
						state_q <= in_rng ? ST_FETCH : ST_DRAIN;
					end
				end
				ST_FETCH: begin
					k_q     <= k_q + 1'b1;
					phase_q <= PH_LL;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					case (phase_q)
						PH_LL: phase_q <= PH_LH;
						PH_LH: phase_q <= PH_HL;
						PH_HL: begin
							if (more_terms) begin
								k_q     <= k_q + 1'b1;
								phase_q <= PH_LL;
							end else begin
								state_q <= ST_DRAIN;
							end
						end
						default: phase_q <= PH_LL;
					endcase
				end
				ST_DRAIN: begin
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// request coordinates and the result word
	always_ff @(posedge clk) begin
		if (accept && (mode == MODE_RD)) begin
			row_q <= row_index;
			col_q <= col_index;
		end
		if (state_q == ST_DRAIN) begin
			res_row_q <= row_q;
			res_col_q <= col_q;
			res_val_q <= acc_sum;
		end
	end

	assign done          = done_q;
	assign result_row    = res_row_q;
	assign result_col    = res_col_q;
	assign product_value = res_val_q;

endmodule

`default_nettype wire

// ===== hw/rtl/imm_checker.sv =====
`default_nettype none

module imm_checker (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic                      busy,
	input  logic [imm_pkg::MODE_W-1:0] mode,
	input  logic                      done
);
	import imm_pkg::*;

	// results never come in two adjacent cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done strobe held for two cycles");

	// a product read always occupies the block
	a_read_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode == MODE_RD)) |=> busy)
		else $error("product read did not raise busy");

	// writes and unused modes finish in the transfer cycle
	a_write_free: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (mode != MODE_RD)) |=> !busy)
		else $error("non-read transfer raised busy");

	// busy ends only with a result
	a_busy_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

endmodule

bind integer_matrix_multiply imm_checker u_imm_checker (.*);

`default_nettype wire

// ===== tb/sv/integer_matrix_multiply_tb.sv =====
`default_nettype none

module integer_matrix_multiply_tb;
	import imm_pkg::*;

	localparam int DIM = 32;
	localparam int CELLS = DIM * DIM;

	// mode 3 has no meaning in the block; register indexes 2 and 3 are unmapped
	localparam logic [MODE_W-1:0]    MODE_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

	// fixed settings for the first phases, phase 0 in the low slot; the rest are random
	localparam int FIXED_PHASES = 12;
	localparam int PHASES = 15;
	localparam int PHASE_ITEMS = 115;
	localparam logic [FIXED_PHASES*SIZE_W-1:0] PHASE_SIZES = {
		6'd40, 6'd32, 6'd5, 6'd2, 6'd16, 6'd0,
		6'd63, 6'd8, 6'd3, 6'd4, 6'd1, 6'd32
	};
	localparam logic [FIXED_PHASES-1:0] PHASE_TRANSPOSED = 12'b1110_0101_1010;

	// long enough for the longest in-range read, at n = 32
	localparam int DRAIN_CYCLES = 3 * DIM + 8;
	localparam int TIMEOUT = 10_000_000;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [IDX_W-1:0]  row;
		logic [IDX_W-1:0]  col;
		logic [VAL_W-1:0]  value;
	} mm_item_t;

	typedef struct packed {
		logic [IDX_W-1:0] row;
		logic [IDX_W-1:0] col;
		logic [VAL_W-1:0] value;
	} mm_product_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic [MODE_W-1:0]     mode = '0;
	logic [IDX_W-1:0]      row_index = '0;
	logic [IDX_W-1:0]      col_index = '0;
	logic [VAL_W-1:0]      element_value = '0;
	logic                  done;
	logic [IDX_W-1:0]      result_row;
	logic [IDX_W-1:0]      result_col;
	logic [VAL_W-1:0]      product_value;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	integer_matrix_multiply #(
		.MAX_DIM(DIM)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.row_index(row_index),
		.col_index(col_index),
		.element_value(element_value),
		.done(done),
		.result_row(result_row),
		.result_col(result_col),
		.product_value(product_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Predictor state: our own copy of both matrices and of the two registers.
	logic [VAL_W-1:0]  a_matrix [0:CELLS-1];
	logic [VAL_W-1:0]  b_matrix [0:CELLS-1];
	logic [SIZE_W-1:0] cfg_size = SIZE_RESET;
	logic              cfg_bt = 1'b0;

	// Generator bookkeeping: which cells have been written since reset, so that
	// no in-range read ever touches a cell the block holds as undefined.
	bit a_written [0:CELLS-1];
	bit b_written [0:CELLS-1];

	mm_item_t    pending [$];
	mm_product_t products_due [$];
	mm_item_t    drive_item;
	mm_product_t want;
	int          gap_left = 0;
	int          burst_left = 0;
	int          items_queued = 0;
	int          failures = 0;

	// Sizes above the array saturate; size zero leaves every index out of range.
	function automatic int size_in_use();
		return (cfg_size > DIM) ? DIM : int'(cfg_size);
	endfunction

	function automatic logic [VAL_W-1:0] dot_product_at(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input int n);
		logic [VAL_W-1:0] acc;
		logic [VAL_W-1:0] b;
		acc = '0;
		for (int k = 0; k < n; k++) begin
			b = cfg_bt ? b_matrix[int'(c) * DIM + k] : b_matrix[k * DIM + int'(c)];
			acc = acc + a_matrix[int'(r) * DIM + k] * b;
		end
		return acc;
	endfunction

	// Apply one accepted transfer to the shadow matrices; a read queues its product.
	function automatic void take_item(input mm_item_t it);
		int          n;
		logic        in_range;
		mm_product_t res;
		n = size_in_use();
		in_range = (int'(it.row) < n) && (int'(it.col) < n);
		case (it.mode)
			MODE_WR_A: begin
				if (in_range) a_matrix[int'(it.row) * DIM + int'(it.col)] = it.value;
			end
			MODE_WR_B: begin
				if (in_range) b_matrix[int'(it.row) * DIM + int'(it.col)] = it.value;
			end
			MODE_RD: begin
				res.row = it.row;
				res.col = it.col;
				res.value = in_range ? dot_product_at(it.row, it.col, n) : '0;
				products_due.push_back(res);
			end
			default: ;
		endcase
	endfunction

	// Mostly back-to-back, sometimes a short gap, now and then a long pause;
	// an occasional burst turns idling off for a stretch.
	function automatic int pick_gap();
		int p;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3) begin
			burst_left = $urandom_range(20, 80);
			return 0;
		end
		if (p < 55) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(4, 40);
	endfunction

	function automatic logic [VAL_W-1:0] rand_word();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return 64'd1;
			3: return 64'h8000_0000_0000_0000;
			4: return 64'($urandom_range(0, 15));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	// Favor indexes inside the active square, with a share outside it.
	function automatic logic [IDX_W-1:0] rand_index(input int n);
		if (n > 0 && $urandom_range(0, 99) < 85) return IDX_W'($urandom_range(0, n - 1));
		return IDX_W'($urandom_range(0, DIM - 1));
	endfunction

	task automatic push_item(input logic [MODE_W-1:0] m, input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c, input logic [VAL_W-1:0] v);
		mm_item_t it;
		int       n;
		n = size_in_use();
		it.mode = m;
		it.row = r;
		it.col = c;
		it.value = v;
		pending.push_back(it);
		if (int'(r) < n && int'(c) < n) begin
			if (m == MODE_WR_A) a_written[int'(r) * DIM + int'(c)] = 1'b1;
			if (m == MODE_WR_B) b_written[int'(r) * DIM + int'(c)] = 1'b1;
		end
		if (m != MODE_UNUSED) items_queued++;
	endtask

	// A product read, preceded by writes of any cell it needs that is still blank.
	task automatic push_read(input logic [IDX_W-1:0] r, input logic [IDX_W-1:0] c);
		int               n;
		int               bcell;
		logic [IDX_W-1:0] kk;
		n = size_in_use();
		if (int'(r) < n && int'(c) < n) begin
			for (int k = 0; k < n; k++) begin
				kk = IDX_W'(k);
				if (!a_written[int'(r) * DIM + k]) push_item(MODE_WR_A, r, kk, rand_word());
				bcell = cfg_bt ? int'(c) * DIM + k : k * DIM + int'(c);
				if (!b_written[bcell]) begin
					if (cfg_bt) push_item(MODE_WR_B, c, kk, rand_word());
					else push_item(MODE_WR_B, kk, c, rand_word());
				end
			end
		end
		push_item(MODE_RD, r, c, rand_word());
	endtask

	task automatic random_phase(input int budget);
		int target;
		int pick;
		int n;
		n = size_in_use();
		target = items_queued + budget;
		while (items_queued < target) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				push_read(rand_index(n), rand_index(n));
			end else if (pick < 93) begin
				push_item($urandom_range(0, 1) ? MODE_WR_B : MODE_WR_A,
					rand_index(n), rand_index(n), rand_word());
			end else begin
				// noise: the block drops it
				push_item(MODE_UNUSED, IDX_W'($urandom_range(0, DIM - 1)),
					IDX_W'($urandom_range(0, DIM - 1)), rand_word());
			end
		end
	endtask

	// Hold until every transfer is taken, every product has come back and the
	// block is idle, then leave time for a trailing element write.
	task automatic wait_idle();
		do @(posedge clk);
		while (pending.size() != 0 || start || busy || products_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// The block latches the register at the edge that ends the enable cycle;
	// update the shadow copy at that same edge.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIZE: cfg_size = data;
			REG_BT:   cfg_bt = data[0];
			default:  ;
		endcase
	endtask

	// Driver: offer the head of the pending queue, hold it while busy, and
	// run the shadow model on each transfer at the edge that accepts it.
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) take_item(drive_item);
			if (start && busy) begin
				// hold the offered item and its fields
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				start <= 1'b0;
			end else if (pending.size() > 0) begin
				drive_item = pending.pop_front();
				mode <= drive_item.mode;
				row_index <= drive_item.row;
				col_index <= drive_item.col;
				element_value <= drive_item.value;
				start <= 1'b1;
				gap_left <= pick_gap();
			end else begin
				start <= 1'b0;
			end
		end
	end

	// Monitor: every strobe is a transfer that must match the oldest product due.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (products_due.size() == 0) begin
				$display("%0t: result with none due: row %0d col %0d value %h",
					$time, result_row, result_col, product_value);
				failures++;
			end else begin
				want = products_due.pop_front();
				if (result_row !== want.row) begin
					$display("%0t: result_row expected %0d actual %0d",
						$time, want.row, result_row);
					failures++;
				end
				if (result_col !== want.col) begin
					$display("%0t: result_col expected %0d actual %0d",
						$time, want.col, result_col);
					failures++;
				end
				if (product_value !== want.value) begin
					$display("%0t: product_value at (%0d,%0d) expected %h actual %h",
						$time, want.row, want.col, want.value, product_value);
					failures++;
				end
			end
		end
	end

	initial begin : stimulus
		logic [SIZE_W-1:0] sz;
		logic              tr;
		for (int i = 0; i < CELLS; i++) begin
			a_matrix[i] = '0;
			b_matrix[i] = '0;
		end
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings (size 32, not transposed): writes on the corners with
		// extreme values, and the unused mode with all fields high and low.
		push_item(MODE_WR_A, 5'd31, 5'd31, '1);
		push_item(MODE_WR_B, 5'd31, 5'd31, '1);
		push_item(MODE_WR_A, 5'd0, 5'd0, '1);
		push_item(MODE_WR_B, 5'd0, 5'd0, '1);
		push_item(MODE_UNUSED, 5'd31, 5'd31, '1);
		push_item(MODE_UNUSED, 5'd0, 5'd0, '0);
		wait_idle();

		// Size one: all-ones squared wraps to one; everything else is out of range.
		write_register(REG_SIZE, 6'd1);
		push_read(5'd0, 5'd0);
		push_read(5'd0, 5'd1);
		push_read(5'd31, 5'd31);
		push_read(5'd31, 5'd0);
		push_item(MODE_WR_A, 5'd0, 5'd1, 64'd5);
		push_item(MODE_WR_B, 5'd1, 5'd0, 64'd7);
		push_read(5'd0, 5'd0);
		wait_idle();

		// Size two with B transposed.
		write_register(REG_SIZE, 6'd2);
		write_register(REG_BT, 6'd1);
		push_item(MODE_WR_A, 5'd0, 5'd1, 64'd2);
		push_item(MODE_WR_B, 5'd0, 5'd1, 64'd3);
		push_read(5'd0, 5'd0);
		push_read(5'd1, 5'd1);
		push_read(5'd1, 5'd0);
		wait_idle();

		// Size zero: every read gives zero and the write to the origin is dropped.
		write_register(REG_SIZE, 6'd0);
		push_read(5'd0, 5'd0);
		push_item(MODE_WR_A, 5'd0, 5'd0, 64'd5);
		push_read(5'd31, 5'd31);
		wait_idle();

		// Unmapped register indexes must not disturb anything.
		write_register(REG_SPARE_2, '1);
		write_register(REG_SPARE_3, 6'h2a);

		for (int p = 0; p < PHASES; p++) begin
			if (p < FIXED_PHASES) begin
				sz = PHASE_SIZES[p*SIZE_W +: SIZE_W];
				tr = PHASE_TRANSPOSED[p];
			end else begin
				sz = SIZE_W'($urandom_range(0, 63));
				tr = 1'($urandom_range(0, 1));
			end
			// upper data bits of the transpose write are don't-care; toggle them
			write_register(REG_BT, {5'($urandom_range(0, 31)), tr});
			write_register(REG_SIZE, sz);
			if ($urandom_range(0, 3) == 0)
				write_register($urandom_range(0, 1) ? REG_SPARE_2 : REG_SPARE_3,
					6'($urandom_range(0, 63)));
			random_phase(PHASE_ITEMS);
			wait_idle();
		end

		// Drain: nothing due, then wait out a full read for stray strobes.
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (products_due.size() != 0) begin
			$display("%0t: %0d products never returned, first at (%0d,%0d) value %h",
				$time, products_due.size(), products_due[0].row, products_due[0].col,
				products_due[0].value);
			failures++;
		end
		if (failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#TIMEOUT;
		$display("%0t: timeout", $time);
		$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
